FILE: rtl/core/arc_ellipse_polyline_generator_unit_defines.svh
// assertion macros shared by the arc and ellipse polyline generator
// no dependencies
`ifndef ARC_ELLIPSE_POLYLINE_GENERATOR_UNIT_DEFINES_SVH
`define ARC_ELLIPSE_POLYLINE_GENERATOR_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define AEP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define AEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/aep_pkg.sv
// types and constants for the arc and ellipse polyline generator
// no dependencies
`default_nettype none
package aep_pkg;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] major_radius;
    logic signed [31:0] minor_radius;
    logic signed [23:0] start_ang;
    logic signed [23:0] sweep_ang;
    logic signed [23:0] rot_ang;
  } aep_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [5:0]  point_number;
    logic               last_point;
  } aep_out_t;

  localparam logic signed [39:0] PiQ28     = 40'sd843314857;
  localparam logic signed [39:0] TwoPiQ28  = 40'sd1686629713;
  localparam logic signed [39:0] HalfPiQ28 = 40'sd421657428;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;
  localparam logic signed [33:0] OneQ30    = 34'sd1073741824;
  localparam int AtanEntries = 28;
  localparam logic [30:0] TolReset = 31'd6554;
  localparam int CmdEllipse = 1;

  // register address of the chord tolerance
  localparam logic [1:0] AddrTol = 2'd0;

  // divider numerator selects
  localparam logic [1:0] DivHalf  = 2'd0;
  localparam logic [1:0] DivPoint = 2'd1;

  // cordic angle selects
  localparam logic [1:0] AngHalf  = 2'd0;
  localparam logic [1:0] AngRot   = 2'd1;
  localparam logic [1:0] AngPoint = 2'd2;

  // arctangent table in Q4.28
  function automatic logic [27:0] atan_q28(input logic [4:0] k);
    logic [27:0] v;
    case (k)
      5'd0:  v = 28'd210828714;
      5'd1:  v = 28'd124459457;
      5'd2:  v = 28'd65760959;
      5'd3:  v = 28'd33381290;
      5'd4:  v = 28'd16755422;
      5'd5:  v = 28'd8385879;
      5'd6:  v = 28'd4193963;
      5'd7:  v = 28'd2097109;
      5'd8:  v = 28'd1048571;
      5'd9:  v = 28'd524287;
      default: v = (k < 5'd28) ? (28'd262144 >> (k - 5'd10)) : 28'd0;
    endcase
    return v;
  endfunction

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIV_START, OP_DIV_STEP, OP_CORDIC_START, OP_CORDIC_STEP,
    OP_TEST, OP_ROT_SAVE, OP_MUL1, OP_MUL2, OP_MUL3, OP_OUT
  } aep_op_e;

  typedef struct packed {
    aep_op_e    op;
    logic [1:0] div_sel;   // half angle or point offset
    logic [1:0] ang_sel;   // half angle, rotation or point angle
  } aep_cmd_t;

  typedef struct packed {
    logic       degenerate;
    logic       ellipse;
    logic       tol_zero;
    logic       test_pass;
    logic       div_done;
    logic       cordic_done;
  } aep_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/aep_datapath.sv
// arithmetic for the polyline generator: divider, cordic, multiplier, output register
// depends on aep_pkg
`default_nettype none
module aep_datapath import aep_pkg::*; #(
  parameter int CORDIC_STEPS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire aep_in_t     in_item,
  input  wire logic [30:0] tol,
  input  wire aep_cmd_t    cmd,
  input  wire logic [5:0]  k_val,
  input  wire logic [5:0]  i_val,
  input  wire logic        last_flag,
  output aep_sts_t         sts,
  output aep_out_t         out_item
);
  localparam int StepsUsed = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

  aep_in_t cur_r;
  // divider: unsigned restoring, 40-bit numerator, 6-bit divisor
  logic [39:0] dq_r, dq_nxt;
  logic [6:0]  drem_r, drem_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        ddone_r, ddone_nxt;
  // cordic
  logic signed [39:0] ca_r, ca_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [4:0] ck_r, ck_nxt;
  logic       cflip_r, cflip_nxt, cbusy_r, cbusy_nxt, cdone_r, cdone_nxt;
  logic signed [33:0] cos_r, sin_r, cr_r, sr_r;
  // multiplier stage registers
  logic signed [33:0] xc_r, yc_r;
  logic signed [63:0] pa_r, pb_r;
  logic               pass_r;
  aep_out_t out_r;

  logic [23:0] mag;
  assign mag = cur_r.sweep_ang[23] ? 24'(-cur_r.sweep_ang) : cur_r.sweep_ang;

  function automatic logic signed [63:0] rnd30(input logic signed [95:0] p);
    logic signed [95:0] t;
    t = (p + 96'sd536870912) >>> 30;
    return t[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // divider step logic
  logic [6:0] trial;
  always_comb begin
    dq_nxt = dq_r; drem_nxt = drem_r; dcnt_nxt = dcnt_r; ddone_nxt = ddone_r;
    trial = '0;
    if (cmd.op == OP_DIV_START) begin
      drem_nxt = '0; dcnt_nxt = 6'd40; ddone_nxt = 1'b0;
      if (cmd.div_sel == DivHalf) dq_nxt = {9'd0, mag, 7'd0};
      else dq_nxt = 40'(i_val * mag + 30'(k_val >> 1));
    end else if (cmd.op == OP_DIV_STEP && !ddone_r) begin
      trial = {drem_r[5:0], dq_r[39]};
      if (trial >= {1'b0, k_val}) begin
        drem_nxt = trial - {1'b0, k_val};
        dq_nxt = {dq_r[38:0], 1'b1};
      end else begin
        drem_nxt = trial;
        dq_nxt = {dq_r[38:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - 6'd1;
      if (dcnt_r == 6'd1) ddone_nxt = 1'b1;
    end
  end

  // cordic angle preparation and iteration
  logic signed [39:0] ang, a0;
  logic               flip0;
  logic signed [33:0] xs, ys;
  logic signed [39:0] ofs;
  always_comb begin
    ofs = cur_r.sweep_ang[23] ? -$signed(dq_r) : $signed(dq_r);
    case (cmd.ang_sel)
      AngHalf: ang = $signed(dq_r);
      AngRot:  ang = 40'(cur_r.rot_ang) <<< 8;
      default: ang = (40'(cur_r.start_ang) + ofs) <<< 8;
    endcase
    // three folds reach any point angle
    a0 = ang;
    if (a0 > PiQ28) a0 = a0 - TwoPiQ28;
    else if (a0 < -PiQ28) a0 = a0 + TwoPiQ28;
    if (a0 > PiQ28) a0 = a0 - TwoPiQ28;
    else if (a0 < -PiQ28) a0 = a0 + TwoPiQ28;
    if (a0 > PiQ28) a0 = a0 - TwoPiQ28;
    else if (a0 < -PiQ28) a0 = a0 + TwoPiQ28;
    flip0 = 1'b0;
    if (a0 > HalfPiQ28) begin a0 = PiQ28 - a0; flip0 = 1'b1; end
    else if (a0 < -HalfPiQ28) begin a0 = -PiQ28 - a0; flip0 = 1'b1; end
    xs = cx_r >>> ck_r;
    ys = cy_r >>> ck_r;
    ca_nxt = ca_r; cx_nxt = cx_r; cy_nxt = cy_r; ck_nxt = ck_r;
    cflip_nxt = cflip_r; cbusy_nxt = cbusy_r; cdone_nxt = cdone_r;
    if (cmd.op == OP_CORDIC_START) begin
      ca_nxt = a0; cflip_nxt = flip0; cx_nxt = GainQ30; cy_nxt = '0;
      ck_nxt = '0; cbusy_nxt = 1'b1; cdone_nxt = 1'b0;
    end else if (cbusy_r) begin
      if (ca_r >= 0) begin
        cx_nxt = cx_r - ys; cy_nxt = cy_r + xs; ca_nxt = ca_r - 40'(atan_q28(ck_r));
      end else begin
        cx_nxt = cx_r + ys; cy_nxt = cy_r - xs; ca_nxt = ca_r + 40'(atan_q28(ck_r));
      end
      ck_nxt = ck_r + 5'd1;
      if (32'(ck_r) == StepsUsed - 1) begin cbusy_nxt = 1'b0; cdone_nxt = 1'b1; end
    end
  end

  logic [33:0]        ccl;
  logic [65:0]        tprod;
  always_comb begin
    if (cos_r < 0) ccl = '0;
    else if (cos_r > OneQ30) ccl = OneQ30;
    else ccl = cos_r;
  end
  logic [31:0] r_eff;
  assign r_eff = (cur_r.cmd && cur_r.minor_radius < cur_r.major_radius) ?
                 cur_r.minor_radius : cur_r.major_radius;
  assign tprod = 66'(r_eff) * 66'(OneQ30 - ccl);

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ddone_r <= 1'b0; cbusy_r <= 1'b0; cdone_r <= 1'b0; dcnt_r <= '0;
    end else begin
      ddone_r <= ddone_nxt; cbusy_r <= cbusy_nxt; cdone_r <= cdone_nxt; dcnt_r <= dcnt_nxt;
    end
    dq_r <= dq_nxt; drem_r <= drem_nxt;
    ca_r <= ca_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt; ck_r <= ck_nxt; cflip_r <= cflip_nxt;
    if (cmd.op == OP_LOAD) begin
      cur_r <= in_item; cr_r <= OneQ30; sr_r <= '0;
    end
    if (cdone_nxt && !cdone_r) begin cos_r <= cflip_nxt ? -cx_nxt : cx_nxt; sin_r <= cy_nxt; end
    if (cmd.op == OP_TEST) pass_r <= (tprod >> 30) <= 66'(tol);
    if (cmd.op == OP_ROT_SAVE) begin cr_r <= cos_r; sr_r <= sin_r; end
    // products registered between steps
    if (cmd.op == OP_MUL1) begin
      xc_r <= 34'(rnd30(96'(cur_r.major_radius) * 96'(cos_r)));
      yc_r <= 34'(rnd30(96'(cur_r.cmd ? cur_r.minor_radius : cur_r.major_radius) *
                        96'(sin_r)));
    end
    if (cmd.op == OP_MUL2) begin
      if (cur_r.cmd) begin
        pa_r <= 64'(xc_r * cr_r - yc_r * sr_r);
        pb_r <= 64'(xc_r * sr_r + yc_r * cr_r);
      end else begin
        pa_r <= 64'(xc_r) <<< 30; pb_r <= 64'(yc_r) <<< 30;
      end
    end
    if (cmd.op == OP_MUL3) begin
      out_r.point_x <= sat32(64'(cur_r.center_x) + rnd30(96'(pa_r)));
      out_r.point_y <= sat32(64'(cur_r.center_y) + rnd30(96'(pb_r)));
      out_r.point_number <= i_val;
      out_r.last_point <= last_flag;
    end
  end

  assign sts.degenerate = ($signed(cur_r.major_radius) <= 0) ||
                          (cur_r.cmd && $signed(cur_r.minor_radius) <= 0) ||
                          (cur_r.sweep_ang == '0);
  assign sts.ellipse     = cur_r.cmd;
  assign sts.tol_zero    = (tol == '0);
  assign sts.test_pass   = pass_r;
  assign sts.div_done    = ddone_r;
  assign sts.cordic_done = cdone_r;
  assign out_item        = out_r;

  logic unused_ok;
  assign unused_ok = ^{drem_r[6], trial[6]};
endmodule
`default_nettype wire

FILE: rtl/core/aep_control.sv
// sequencer for the polyline generator: segment search (skipped at zero tolerance) then point loop
// depends on aep_pkg and the shared assertion macros
`default_nettype none
`include "arc_ellipse_polyline_generator_unit_defines.svh"
module aep_control import aep_pkg::*; #(
  parameter int MAX_SEGMENTS = 63
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire aep_sts_t sts,
  output aep_cmd_t      cmd,
  output logic [5:0]    k_val,
  output logic [5:0]    i_val,
  output logic          last_flag
);
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001, S_CHECK = 14'b00000000000010,
    S_HDIV  = 14'b00000000000100, S_HCOR  = 14'b00000000001000,
    S_TEST  = 14'b00000000010000, S_JUDGE = 14'b00000000100000,
    S_RCOR  = 14'b00000001000000, S_PDIV  = 14'b00000010000000,
    S_PCOR  = 14'b00000100000000, S_MUL1  = 14'b00001000000000,
    S_MUL2  = 14'b00010000000000, S_MUL3  = 14'b00100000000000,
    S_OUT   = 14'b01000000000000, S_ROT   = 14'b10000000000000
  } state_t;

  localparam logic [5:0] MaxSeg = 6'(MAX_SEGMENTS);

  state_t state_r, state_nxt;
  logic [5:0] k_r, k_nxt, n_r, n_nxt, i_r, i_nxt;
  logic       first_r, first_nxt, ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r; k_nxt = k_r; n_nxt = n_r; i_nxt = i_r;
    first_nxt = 1'b0; ov_nxt = ov_r;
    cmd = '{op: OP_NONE, div_sel: DivHalf, ang_sel: AngHalf};
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin cmd.op = OP_LOAD; state_nxt = S_CHECK; end
      S_CHECK: begin
        if (sts.degenerate) state_nxt = S_IDLE;
        else if (sts.tol_zero) begin n_nxt = MaxSeg; state_nxt = S_ROT; end
        else begin
          k_nxt = sts.ellipse ? 6'd8 : 6'd4;
          cmd.op = OP_DIV_START; cmd.div_sel = DivHalf; state_nxt = S_HDIV;
        end
      end
      S_HDIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) begin cmd.op = OP_CORDIC_START; first_nxt = 1'b1; state_nxt = S_HCOR; end
      end
      S_HCOR: if (sts.cordic_done && !first_r) begin cmd.op = OP_TEST; state_nxt = S_JUDGE; end
      S_JUDGE: begin
        if (sts.test_pass) begin n_nxt = k_r; state_nxt = S_ROT; end
        else if (k_r + 6'd1 >= MaxSeg) begin n_nxt = MaxSeg; state_nxt = S_ROT; end
        else begin
          k_nxt = k_r + 6'd1; cmd.op = OP_DIV_START; state_nxt = S_HDIV;
        end
      end
      // divisor and point index settle before the first point division
      S_ROT: begin
        k_nxt = n_r; i_nxt = '0;
        if (sts.ellipse) begin
          cmd.op = OP_CORDIC_START; cmd.ang_sel = AngRot; first_nxt = 1'b1; state_nxt = S_RCOR;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_RCOR: if (sts.cordic_done && !first_r) begin
        cmd.op = OP_ROT_SAVE; state_nxt = S_TEST;
      end
      S_TEST: begin cmd.op = OP_DIV_START; cmd.div_sel = DivPoint; state_nxt = S_PDIV; end
      S_PDIV: begin
        cmd.op = OP_DIV_STEP;
        if (sts.div_done) begin
          cmd.op = OP_CORDIC_START; cmd.ang_sel = AngPoint; first_nxt = 1'b1; state_nxt = S_PCOR;
        end
      end
      S_PCOR: if (sts.cordic_done && !first_r) begin cmd.op = OP_MUL1; state_nxt = S_MUL1; end
      S_MUL1: begin cmd.op = OP_MUL2; state_nxt = S_MUL2; end
      S_MUL2: if (!ov_r || !out_stall) begin cmd.op = OP_MUL3; state_nxt = S_MUL3; end
      S_MUL3: begin
        cmd.op = OP_OUT; ov_nxt = 1'b1;
        if (i_r == n_r) state_nxt = S_IDLE;
        else begin i_nxt = i_r + 6'd1; state_nxt = S_OUT; end
      end
      S_OUT: begin
        cmd.op = OP_DIV_START; cmd.div_sel = DivPoint; state_nxt = S_PDIV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; k_r <= '0; n_r <= '0; i_r <= '0; first_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; k_r <= k_nxt; n_r <= n_nxt; i_r <= i_nxt;
      first_r <= first_nxt; ov_r <= ov_nxt;
    end
  end

  // the last point may wait in the output register while the next curve is taken
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign k_val     = k_r;
  assign i_val     = i_r;
  assign last_flag = (i_r == n_r);

  // sanity of the sequencer
  `AEP_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_r), "state not one-hot")
  `AEP_ASSERT_IMP(a_n_range, state_r == S_PCOR, n_r != 6'd0 && n_r <= MaxSeg, "bad count")
  `AEP_ASSERT_IMP(a_i_range, state_r == S_MUL3, i_r <= n_r, "point index beyond count")
  `AEP_ASSERT_NEXT(a_hold, ov_r && out_stall, ov_r, "result dropped while stalled")
endmodule
`default_nettype wire

FILE: rtl/core/arc_ellipse_polyline_generator_unit.sv
// Arc and ellipse polyline generator. One curve is taken at a time; after a
// segment search (one division and one CORDIC pass per candidate count, from
// 4 or 8 upward; skipped when the tolerance is zero) each of the n+1 points
// costs one division, one CORDIC pass and three multiply steps, plus any
// output stall. An ellipse adds one CORDIC pass. The input is held off until
// the last point of the current curve sits in the output register. Degenerate
// curves produce nothing and release the input right after the check state.
// depends on aep_pkg, aep_control, aep_datapath
`default_nettype none
module arc_ellipse_polyline_generator_unit import aep_pkg::*; #(
  parameter int MAX_SEGMENTS = 63,
  parameter int CORDIC_STEPS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire aep_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output aep_out_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [30:0] tol_r;
  aep_cmd_t cmd;
  aep_sts_t sts;
  logic [5:0] k_val, i_val;
  logic last_flag;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TolReset;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == AddrTol) tol_r <= cfg_pwdata[30:0];
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == AddrTol) ? {1'b0, tol_r} : 32'd0;

  aep_control #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd, .k_val, .i_val, .last_flag
  );

  aep_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk, .rst_n, .in_item(in_data), .tol(tol_r), .cmd, .k_val, .i_val, .last_flag,
    .sts, .out_item(out_data)
  );
endmodule
`default_nettype wire

FILE: tb/aep_checker.sv
// curve-to-point predictor and result scoreboard for the arc and ellipse polyline generator
// depends on aep_pkg; watches the input, result and register ports of the block
`default_nettype none
module aep_checker import aep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire aep_in_t     in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire aep_out_t    out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSeg = 63;
  localparam int Steps = 20;
  localparam logic [1:0] TolAddr = 2'd0;
  localparam longint Pi = 843314857;
  localparam longint TwoPi = 1686629713;
  localparam longint HalfPi = 421657428;
  localparam longint Gain = 652032874;
  localparam longint One = 1073741824;
  localparam longint ArcTab [28] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  logic [30:0] tolerance;
  aep_out_t    point_q[$];

  // rotation-mode cordic, angle in Q4.28, results in Q2.30
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, t;
    bit flip;
    x = Gain;
    y = 0;
    flip = 0;
    while (ang > Pi) ang -= TwoPi;
    while (ang < -Pi) ang += TwoPi;
    if (ang > HalfPi) begin
      ang = Pi - ang;
      flip = 1;
    end else if (ang < -HalfPi) begin
      ang = -Pi - ang;
      flip = 1;
    end
    for (int k = 0; k < Steps && k < 28; k++) begin
      if (ang >= 0) begin
        t = x - (y >>> k); y = y + (x >>> k); ang -= ArcTab[k];
      end else begin
        t = x + (y >>> k); y = y - (x >>> k); ang += ArcTab[k];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = y;
  endfunction

  function automatic longint round_q30(input longint p);
    return (p + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // smallest segment count whose chord height error fits the tolerance
  function automatic int seg_count(input longint r, input longint mag, input int lo);
    longint c, s;
    if (tolerance == 0) return MaxSeg;
    for (int k = lo; k < MaxSeg; k++) begin
      sin_cos((mag * 128) / k, c, s);
      if (c < 0) c = 0;
      if (c > One) c = One;
      if (((r * (One - c)) >>> 30) <= longint'(tolerance)) return k;
    end
    return MaxSeg;
  endfunction

  // expand one curve into its expected polyline points
  task automatic predict_curve(input aep_in_t d);
    longint cx, cy, ra, rb, st, sw, rot, mag, r, cr, sr, off, c, s, xc, yc, px, py;
    int n;
    bit ell;
    aep_out_t p;
    ell = d.cmd;
    cx = d.center_x; cy = d.center_y;
    ra = d.major_radius; rb = d.minor_radius;
    st = d.start_ang; sw = d.sweep_ang; rot = d.rot_ang;
    mag = sw < 0 ? -sw : sw;
    cr = One;
    sr = 0;
    if (ra <= 0 || (ell && rb <= 0) || sw == 0) return;
    r = (ell && rb < ra) ? rb : ra;
    n = seg_count(r, mag, ell ? 8 : 4);
    if (ell) sin_cos(rot * 256, cr, sr);
    for (int i = 0; i <= n; i++) begin
      off = (longint'(i) * mag + n / 2) / n;
      sin_cos((st + (sw < 0 ? -off : off)) * 256, c, s);
      if (ell) begin
        xc = round_q30(ra * c);
        yc = round_q30(rb * s);
        px = cx + round_q30(xc * cr - yc * sr);
        py = cy + round_q30(xc * sr + yc * cr);
      end else begin
        px = cx + round_q30(ra * c);
        py = cy + round_q30(ra * s);
      end
      p.point_x = clip32(px);
      p.point_y = clip32(py);
      p.point_number = i[5:0];
      p.last_point = (i == n);
      point_q = {point_q, p};
    end
  endtask

  // register shadow, prediction and comparison
  always @(posedge clk) begin
    aep_out_t e;
    if (!rst_n) begin
      tolerance = TolReset;
      point_q.delete();
      errors = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == TolAddr)
        tolerance = cfg_pwdata[30:0];
      if (out_valid && !out_stall) begin
        if (point_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected point %h", out_data);
        end else begin
          e = point_q.pop_front();
          if (e.point_x !== out_data.point_x || e.point_y !== out_data.point_y ||
              e.point_number !== out_data.point_number ||
              e.last_point !== out_data.last_point) begin
            errors++;
            if (errors <= 10)
              $display("point mismatch: exp x=%h y=%h n=%0d l=%b got x=%h y=%h n=%0d l=%b",
                       e.point_x, e.point_y, e.point_number, e.last_point,
                       out_data.point_x, out_data.point_y, out_data.point_number,
                       out_data.last_point);
          end
        end
      end
      if (in_valid && !in_stall) predict_curve(in_data);
    end
    pending = point_q.size();
  end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// stimulus and verdict for the arc and ellipse polyline generator
// depends on aep_pkg, aep_checker and the block arc_ellipse_polyline_generator_unit
`default_nettype none
module tb;
  import aep_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] TolAddr = 2'd0;
  localparam longint CycleLimit = 40000000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  aep_in_t in_data = '0;
  aep_out_t out_data;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0, cfg_pready;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  int errors, pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_req = 0, hold_done = 0;
  int hold_cnt = 0;
  longint cycles = 0;

  arc_ellipse_polyline_generator_unit u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready);

  aep_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .errors, .pending);

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall plus one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 5000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall = 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle);
    end
  end

  task automatic reg_write(input logic [31:0] v);
    @(negedge clk);
    cfg_psel = 1; cfg_pwrite = 1; cfg_paddr = TolAddr; cfg_pwdata = v; cfg_penable = 0;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  // offer one curve item and hold it until taken
  task automatic send_curve(input aep_in_t d);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic aep_in_t rand_curve();
    aep_in_t d;
    d.cmd = 1'($urandom_range(1));
    d.center_x = $urandom;
    d.center_y = $urandom;
    d.start_ang = 24'($urandom);
    d.rot_ang = 24'($urandom);
    if ($urandom_range(99) < 85) begin
      d.major_radius = $urandom_range(32'h400000, 32'h4000);
      d.minor_radius = $urandom_range(32'h400000, 32'h4000);
      d.sweep_ang = 24'($urandom_range(8388607, 1));
      if ($urandom_range(1)) d.sweep_ang = -d.sweep_ang;
    end else begin
      d.major_radius = $urandom;
      d.minor_radius = $urandom;
      d.sweep_ang = 24'($urandom);
    end
    return d;
  endfunction

  function automatic aep_in_t curve(input logic k, input logic [31:0] cx, cy, ra, rb,
                                    input logic [23:0] st, sw, rot);
    aep_in_t d;
    d.cmd = k; d.center_x = cx; d.center_y = cy; d.major_radius = ra; d.minor_radius = rb;
    d.start_ang = st; d.sweep_ang = sw; d.rot_ang = rot;
    return d;
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1;
    send_idle = 34; recv_idle = 53;

    // directed curves at the reset tolerance
    send_curve(curve(1'b0, 0, 0, 32'h10000, 0, 24'd0, 24'h6487ed, 24'd0));
    send_curve(curve(1'b1, 32'h10000, 32'hffff0000, 32'h30000, 32'h10000, 24'h100000,
                     24'h3243f6, 24'h0c90fd));
    send_curve(curve(1'b0, 0, 0, 32'h20000, 0, 24'd0, 24'hcdb812, 24'd0));
    send_curve(curve(1'b0, 0, 0, 32'h10000, 0, 24'h100000, 24'd0, 24'd0));
    send_curve(curve(1'b0, 0, 0, 0, 0, 24'd0, 24'h100000, 24'd0));
    send_curve(curve(1'b0, 0, 0, 32'h80000000, 0, 24'd0, 24'h100000, 24'd0));
    send_curve(curve(1'b1, 0, 0, 32'h10000, 0, 24'd0, 24'h100000, 24'd0));
    send_curve(curve(1'b1, 0, 0, 32'h10000, 32'hfff00000, 24'd0, 24'h100000, 24'd0));
    send_curve(curve(1'b1, 0, 0, 32'h10000, 32'h40000, 24'h7fffff, 24'h7fffff, 24'h800000));
    send_curve(curve(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 24'h800000,
                     24'h7fffff, 24'd0));
    send_curve(curve(1'b0, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 24'h7fffff,
                     24'h800000, 24'd0));
    send_curve(curve(1'b1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     24'h400000, 24'h000001, 24'h7fffff));
    send_curve(curve(1'b0, 32'h12345678, 32'hedcba987, 32'h1, 0, 24'd0, 24'hffffff, 24'd0));
    send_curve(curve(1'b1, 0, 0, 32'h1, 32'h1, 24'd0, 24'h1, 24'h800000));
    drain();

    // zero tolerance saturates every count
    reg_write(32'h0);
    repeat (4) send_curve(rand_curve());
    drain();

    // widest tolerance gives the minimum counts
    reg_write(32'hffffffff);
    repeat (12) send_curve(rand_curve());
    drain();

    // roles swap, then a long result hold-off while curves keep coming
    reg_write(32'h10000);
    send_idle = 53; recv_idle = 34;
    repeat (60) send_curve(rand_curve());
    hold_req = 1;
    repeat (10) send_curve(rand_curve());
    drain();

    // no idling at a random tolerance
    reg_write($urandom_range(32'h40000, 32'h100));
    send_idle = 0; recv_idle = 0;
    repeat (60) send_curve(rand_curve());
    drain();
    repeat (200) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: arc_ellipse_polyline_generator_unit.f
+incdir+rtl/core
rtl/core/aep_pkg.sv
rtl/core/aep_datapath.sv
rtl/core/aep_control.sv
rtl/core/arc_ellipse_polyline_generator_unit.sv
tb/aep_checker.sv
tb/tb.sv
